// ===== rtl/utf8d_pkg.sv =====
// utf8d_pkg: types and constants shared by the utf-8 code point decoder
// no dependencies; compiled first

package utf8d_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] CP_REPLACEMENT = 21'h00FFFD;

  localparam logic [7:0] ASCII_LIMIT  = 8'h80;
  localparam logic [7:0] LEAD2_MASK   = 8'hE0;
  localparam logic [7:0] LEAD2_CODE   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK   = 8'hF0;
  localparam logic [7:0] LEAD3_CODE   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK   = 8'hF8;
  localparam logic [7:0] LEAD4_CODE   = 8'hF0;
  localparam logic [7:0] CONT_MASK    = 8'hC0;
  localparam logic [7:0] CONT_CODE    = 8'h80;
  localparam logic [7:0] CONT_PAYLOAD = 8'h3F;
  localparam logic [7:0] LEAD2_PAYLOAD = 8'h1F;
  localparam logic [7:0] LEAD3_PAYLOAD = 8'h0F;
  localparam logic [7:0] LEAD4_PAYLOAD = 8'h07;

  typedef logic [CpW-1:0] cp_t;

  typedef struct packed {
    logic [1:0] pending;
    cp_t        partial;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] count;
    cp_t        cp0;
    cp_t        cp1;
  } dec_result_t;

endpackage

// ===== rtl/utf8d_if.sv =====
// utf8d_in_if / utf8d_out_if: valid-ready channels of the utf-8 decoder
// depends on utf8d_pkg

interface utf8d_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_string;

  modport source (output valid, output data_byte, output end_of_string, input ready);
  modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface utf8d_out_if;
  logic                     valid;
  logic                     ready;
  logic [utf8d_pkg::CpW-1:0] code_point;
  logic                     last_of_run;

  modport source (output valid, output code_point, output last_of_run, input ready);
  modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// ===== rtl/utf8_codepoint_decoder.sv =====
// utf8_codepoint_decoder: utf-8 byte stream to code points, top level
// depends on utf8d_pkg, utf8d_if, utf8d_dec
//
//   channel  | dir | payload                      | transfer
//   in_chan  | in  | data_byte[7:0], end_of_string | valid & ready
//   out_chan | out | code_point[20:0], last_of_run | valid & ready
//
// one byte is taken per cycle, while the result queue can accept it, into an
// input register, decoded in one pass and moved into a two-slot result queue;
// a byte giving two results holds off the next byte until its second is taken
// output stall backs up through the queue and the input register to in_chan.ready
// synchronous active-low reset closes any open sequence and empties both stages

module utf8_codepoint_decoder (
  input  logic        clk,
  input  logic        rst_n,
  utf8d_in_if.sink    in_chan,
  utf8d_out_if.source out_chan
);
  import utf8d_pkg::*;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_eos_r;
  logic        s1_move;

  dec_state_t  st_r;
  dec_state_t  st_nxt;
  dec_result_t dec;

  logic [1:0]  res_cnt_r;
  logic [1:0]  res_cnt_nxt;
  cp_t         q0_cp_r;
  logic        q0_last_r;
  cp_t         q1_cp_r;
  logic        q1_last_r;
  logic        pop;
  logic        can_load;

  utf8d_dec u_dec (
    .st            (st_r),
    .data_byte     (s1_byte_r),
    .end_of_string (s1_eos_r),
    .st_nxt        (st_nxt),
    .res           (dec)
  );

  assign pop      = out_chan.valid && out_chan.ready;
  assign can_load = (res_cnt_r == 2'd0) || ((res_cnt_r == 2'd1) && pop);
  assign s1_move  = s1_valid_r && can_load;

  assign in_chan.ready = !s1_valid_r || s1_move;

  assign out_chan.valid       = res_cnt_r != 2'd0;
  assign out_chan.code_point  = q0_cp_r;
  assign out_chan.last_of_run = q0_last_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_byte_r <= in_chan.data_byte;
      s1_eos_r  <= in_chan.end_of_string;
    end
  end

  // sequence state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_move) begin
      st_r <= st_nxt;
    end
  end

  // result queue
  always_comb begin
    res_cnt_nxt = res_cnt_r;
    if (s1_move) begin
      res_cnt_nxt = dec.count;
    end else if (pop) begin
      res_cnt_nxt = res_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
    end else begin
      res_cnt_r <= res_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      q0_cp_r   <= dec.cp0;
      q0_last_r <= dec.count == 2'd1;
      q1_cp_r   <= dec.cp1;
      q1_last_r <= 1'b1;
    end else if (pop) begin
      q0_cp_r   <= q1_cp_r;
      q0_last_r <= q1_last_r;
    end
  end

  // checks
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (dec.count != 2'd3))
    else $error("decoder produced more than two results");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_eos_r) |=> (st_r.pending == 2'd0))
    else $error("sequence left open after end of string");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (dec.count == 2'd2)) |=> (!q0_last_r && (res_cnt_r == 2'd2)))
    else $error("first of two results marked last");

  assert property (@(posedge clk) disable iff (!rst_n)
    ((res_cnt_r == 2'd2) && s1_valid_r) |-> !in_chan.ready)
    else $error("input taken while result queue is full");

endmodule

// ===== rtl/utf8d_dec.sv =====
// utf8d_dec: decode of one byte against the open sequence, up to two results
// depends on utf8d_pkg

module utf8d_dec (
  input  utf8d_pkg::dec_state_t  st,
  input  logic [7:0]             data_byte,
  input  logic                   end_of_string,
  output utf8d_pkg::dec_state_t  st_nxt,
  output utf8d_pkg::dec_result_t res
);
  import utf8d_pkg::*;

  logic is_cont;

  assign is_cont = (data_byte & CONT_MASK) == CONT_CODE;

  always_comb begin
    logic       do_lead;
    logic       emit_a;
    cp_t        val_a;
    logic       emit_b;
    cp_t        val_b;
    logic       emit_c;
    do_lead = 1'b0;
    emit_a  = 1'b0;
    val_a   = CP_REPLACEMENT;
    emit_b  = 1'b0;
    val_b   = CP_REPLACEMENT;
    emit_c  = 1'b0;
    st_nxt  = st;

    // open sequence
    if (st.pending != 2'd0) begin
      if (is_cont) begin
        st_nxt.partial = {st.partial[CpW-7:0], data_byte[5:0] & CONT_PAYLOAD[5:0]};
        st_nxt.pending = st.pending - 2'd1;
        if (st.pending == 2'd1) begin
          emit_a         = 1'b1;
          val_a          = st_nxt.partial;
          st_nxt.partial = '0;
        end
      end else begin
        emit_a  = 1'b1;
        val_a   = CP_REPLACEMENT;
        st_nxt  = '0;
        do_lead = 1'b1;
      end
    end else begin
      do_lead = 1'b1;
    end

    // lead byte
    if (do_lead) begin
      if (data_byte < ASCII_LIMIT) begin
        emit_b = 1'b1;
        val_b  = {{(CpW-8){1'b0}}, data_byte};
      end else if ((data_byte & LEAD2_MASK) == LEAD2_CODE) begin
        st_nxt.pending = 2'd1;
        st_nxt.partial = {{(CpW-8){1'b0}}, data_byte & LEAD2_PAYLOAD};
      end else if ((data_byte & LEAD3_MASK) == LEAD3_CODE) begin
        st_nxt.pending = 2'd2;
        st_nxt.partial = {{(CpW-8){1'b0}}, data_byte & LEAD3_PAYLOAD};
      end else if ((data_byte & LEAD4_MASK) == LEAD4_CODE) begin
        st_nxt.pending = 2'd3;
        st_nxt.partial = {{(CpW-8){1'b0}}, data_byte & LEAD4_PAYLOAD};
      end else begin
        emit_b = 1'b1;
        val_b  = CP_REPLACEMENT;
      end
    end

    // string ends inside a sequence
    if (end_of_string && (st_nxt.pending != 2'd0)) begin
      emit_c = 1'b1;
      st_nxt = '0;
    end

    // pack results in order; at most two of the three can fire
    res.count = {1'b0, emit_a} + {1'b0, emit_b} + {1'b0, emit_c};
    res.cp0   = emit_a ? val_a : (emit_b ? val_b : CP_REPLACEMENT);
    res.cp1   = (emit_a && emit_b) ? val_b : CP_REPLACEMENT;
  end

endmodule
